/* sv/spp_pkg.sv */
// Shared constants and types for the small-angle pinhole projection unit.
`default_nettype none
package spp_pkg;
    localparam int ROT_FRAC  = 16;
    localparam int WORLD_W   = 32;
    localparam int ROT_W     = 18;
    localparam int FOCAL_W   = 16;
    localparam int PIX_W     = 18;
    localparam int CAM_W     = 36;   // rounded camera coordinate
    localparam int NUM_W     = 56;   // 2*num + zc
    localparam int DEN_W     = 36;   // 2*zc
    localparam int REM_W     = 54;
    localparam int CFG_IDX_W = 4;

    localparam logic [12:0] CX_Q4 = 13'd5112;
    localparam logic [12:0] CY_Q4 = 13'd3832;
    localparam logic [FOCAL_W-1:0] FOCAL_RESET = 16'd8400;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 4'd7;

    typedef struct packed {
        logic behind;
        logic sat_hi;
        logic sat_lo;
    } t_div_flags;
endpackage
`default_nettype wire

/* sv/spp_xform.sv */
// Two-stage rigid transform of a world point into rounded camera coordinates.
`default_nettype none
module spp_xform import spp_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic signed [WORLD_W-1:0]  i_xw,
    input  wire logic signed [WORLD_W-1:0]  i_yw,
    input  wire logic signed [WORLD_W-1:0]  i_zw,
    input  wire logic signed [ROT_W-1:0]    i_rx,
    input  wire logic signed [ROT_W-1:0]    i_ry,
    input  wire logic signed [ROT_W-1:0]    i_rz,
    input  wire logic signed [WORLD_W-1:0]  i_tx,
    input  wire logic signed [WORLD_W-1:0]  i_ty,
    input  wire logic signed [WORLD_W-1:0]  i_tz,
    output logic                            o_valid,
    output logic signed [CAM_W-1:0]         o_xc,
    output logic signed [CAM_W-1:0]         o_yc,
    output logic signed [CAM_W-1:0]         o_zc
);
    localparam int P_W = WORLD_W + ROT_W;
    localparam int S_W = 52;

    logic                  r_v1;
    logic signed [P_W-1:0] r_rzyw, r_ryzw, r_rzxw, r_rxzw, r_ryxw, r_rxyw;
    logic signed [WORLD_W:0] r_ax, r_ay, r_az;

    logic signed [S_W-1:0] n_sx, n_sy, n_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
        r_rzyw <= P_W'(i_rz) * P_W'(i_yw);
        r_ryzw <= P_W'(i_ry) * P_W'(i_zw);
        r_rzxw <= P_W'(i_rz) * P_W'(i_xw);
        r_rxzw <= P_W'(i_rx) * P_W'(i_zw);
        r_ryxw <= P_W'(i_ry) * P_W'(i_xw);
        r_rxyw <= P_W'(i_rx) * P_W'(i_yw);
        r_ax   <= {i_xw[WORLD_W-1], i_xw} + {i_tx[WORLD_W-1], i_tx};
        r_ay   <= {i_yw[WORLD_W-1], i_yw} + {i_ty[WORLD_W-1], i_ty};
        r_az   <= {i_zw[WORLD_W-1], i_zw} + {i_tz[WORLD_W-1], i_tz};
        o_xc   <= n_sx[S_W-1:ROT_FRAC];
        o_yc   <= n_sy[S_W-1:ROT_FRAC];
        o_zc   <= n_sz[S_W-1:ROT_FRAC];
    end

    // exact sum with ROT_FRAC extra fraction bits, plus half for round-to-nearest
    localparam logic signed [S_W-1:0] HALF = S_W'(1) <<< (ROT_FRAC - 1);

    always_comb begin
        n_sx = {{(S_W-WORLD_W-1-ROT_FRAC){r_ax[WORLD_W]}}, r_ax, {ROT_FRAC{1'b0}}}
             - S_W'(r_rzyw) + S_W'(r_ryzw) + HALF;
        n_sy = {{(S_W-WORLD_W-1-ROT_FRAC){r_ay[WORLD_W]}}, r_ay, {ROT_FRAC{1'b0}}}
             + S_W'(r_rzxw) - S_W'(r_rxzw) + HALF;
        n_sz = {{(S_W-WORLD_W-1-ROT_FRAC){r_az[WORLD_W]}}, r_az, {ROT_FRAC{1'b0}}}
             - S_W'(r_ryxw) + S_W'(r_rxyw) + HALF;
    end
endmodule
`default_nettype wire

/* sv/spp_proj.sv */
// Two-stage numerator and denominator build for both pixel axes.
`default_nettype none
module spp_proj import spp_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic signed [CAM_W-1:0]  i_xc,
    input  wire logic signed [CAM_W-1:0]  i_yc,
    input  wire logic signed [CAM_W-1:0]  i_zc,
    input  wire logic [FOCAL_W-1:0]       i_fx,
    input  wire logic [FOCAL_W-1:0]       i_fy,
    output logic                          o_valid,
    output logic signed [NUM_W-1:0]       o_nu,
    output logic signed [NUM_W-1:0]       o_nv,
    output logic [DEN_W-1:0]              o_den,
    output logic                          o_behind
);
    localparam int M_W = CAM_W + FOCAL_W + 1;

    logic                    r_v1, r_behind1;
    logic signed [M_W-1:0]   r_fxc, r_fyc, r_cxz, r_cyz;
    logic signed [CAM_W-1:0] r_zc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
        r_fxc     <= M_W'($signed({1'b0, i_fx})) * M_W'(i_xc);
        r_fyc     <= M_W'($signed({1'b0, i_fy})) * M_W'(i_yc);
        r_cxz     <= M_W'($signed({1'b0, CX_Q4})) * M_W'(i_zc);
        r_cyz     <= M_W'($signed({1'b0, CY_Q4})) * M_W'(i_zc);
        r_zc      <= i_zc;
        r_behind1 <= (i_zc[CAM_W-1] || i_zc == '0);
        // 2*num + zc, denominator 2*zc
        o_nu      <= (NUM_W'(r_fxc) + NUM_W'(r_cxz)) * 2 + NUM_W'(r_zc);
        o_nv      <= (NUM_W'(r_fyc) + NUM_W'(r_cyz)) * 2 + NUM_W'(r_zc);
        o_den     <= {r_zc[CAM_W-2:0], 1'b0};
        o_behind  <= r_behind1;
    end
endmodule
`default_nettype wire

/* sv/spp_div.sv */
// Saturating floor divider: range check stage, then one quotient bit per stage.
`default_nettype none
module spp_div import spp_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    input  wire logic                    i_behind,
    output logic                         o_valid,
    output logic [PIX_W-1:0]             o_q,
    output t_div_flags                   o_flags
);
    localparam int STAGES = PIX_W;

    logic signed [NUM_W-1:0] n_dsh, n_sum;
    logic                    r_v   [0:STAGES];
    logic [REM_W-1:0]        r_rem [0:STAGES];
    logic [PIX_W-1:0]        r_q   [0:STAGES];
    logic [DEN_W-1:0]        r_d   [0:STAGES];
    t_div_flags              r_f   [0:STAGES];

    // Offset by 2^17*D so the in-range quotient becomes an unsigned 18-bit value.
    always_comb begin
        n_dsh = NUM_W'({i_den, {(PIX_W-1){1'b0}}});
        n_sum = i_num + n_dsh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else          r_v[0] <= i_valid;
        r_rem[0]        <= n_sum[REM_W-1:0];
        r_q[0]          <= '0;
        r_d[0]          <= i_den;
        r_f[0].behind   <= i_behind;
        r_f[0].sat_hi   <= (i_num >= n_dsh);
        r_f[0].sat_lo   <= (i_num < -n_dsh);
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic [REM_W-1:0] n_trial;
        logic             n_ge;
        always_comb begin
            n_trial = REM_W'(r_d[i]) << (STAGES-1-i);
            n_ge    = (r_rem[i] >= n_trial);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i+1] <= 1'b0;
            else          r_v[i+1] <= r_v[i];
            r_rem[i+1] <= n_ge ? r_rem[i] - n_trial : r_rem[i];
            r_q[i+1]   <= {r_q[i][PIX_W-2:0], n_ge};
            r_d[i+1]   <= r_d[i];
            r_f[i+1]   <= r_f[i];
        end
    end

    always_comb begin
        o_valid = r_v[STAGES];
        o_q     = {~r_q[STAGES][PIX_W-1], r_q[STAGES][PIX_W-2:0]};
        o_flags = r_f[STAGES];
    end
endmodule
`default_nettype wire

/* sv/small_angle_pinhole_projection_unit.sv */
// Top level: config registers, transform, projection, dividers and output register.
//
//  channel  | signals                                     | transfer when
//  ---------+---------------------------------------------+----------------------------
//  point in | start, busy, i_world_x/y/z                  | start && !busy
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index/data  | i_cfg_valid && o_cfg_ready
//  result   | o_valid, o_pixel_u/v, o_behind_camera/_clip | o_valid (one cycle)
//
// One point per cycle; busy stays low. The pipeline runs through the transform,
// numerator, range and 18-stage restoring divider stages and the output register.
// Synchronous active-low reset clears valid bits and restores register defaults.
// The result side has no backpressure, so the pipeline never stalls.
`default_nettype none
module small_angle_pinhole_projection_unit import spp_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [WORLD_W-1:0]   i_world_x,
    input  wire logic signed [WORLD_W-1:0]   i_world_y,
    input  wire logic signed [WORLD_W-1:0]   i_world_z,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data,
    output logic                             o_valid,
    output logic signed [PIX_W-1:0]          o_pixel_u,
    output logic signed [PIX_W-1:0]          o_pixel_v,
    output logic                             o_behind_camera,
    output logic                             o_clipped
);
    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

    logic signed [ROT_W-1:0]   r_rx, r_ry, r_rz;
    logic signed [WORLD_W-1:0] r_tx, r_ty, r_tz;
    logic [FOCAL_W-1:0]        r_fx, r_fy;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx <= '0; r_ry <= '0; r_rz <= '0;
            r_tx <= '0; r_ty <= '0; r_tz <= '0;
            r_fx <= FOCAL_RESET;
            r_fy <= FOCAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ROT_X:   r_rx <= i_cfg_data[ROT_W-1:0];
                REG_ROT_Y:   r_ry <= i_cfg_data[ROT_W-1:0];
                REG_ROT_Z:   r_rz <= i_cfg_data[ROT_W-1:0];
                REG_TRANS_X: r_tx <= i_cfg_data;
                REG_TRANS_Y: r_ty <= i_cfg_data;
                REG_TRANS_Z: r_tz <= i_cfg_data;
                REG_FOCAL_X: r_fx <= i_cfg_data[FOCAL_W-1:0];
                REG_FOCAL_Y: r_fy <= i_cfg_data[FOCAL_W-1:0];
                default: ;
            endcase
        end
    end

    logic                    x_valid;
    logic signed [CAM_W-1:0] x_xc, x_yc, x_zc;

    spp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_xw    (i_world_x),
        .i_yw    (i_world_y),
        .i_zw    (i_world_z),
        .i_rx    (r_rx),
        .i_ry    (r_ry),
        .i_rz    (r_rz),
        .i_tx    (r_tx),
        .i_ty    (r_ty),
        .i_tz    (r_tz),
        .o_valid (x_valid),
        .o_xc    (x_xc),
        .o_yc    (x_yc),
        .o_zc    (x_zc)
    );

    logic                    p_valid, p_behind;
    logic signed [NUM_W-1:0] p_nu, p_nv;
    logic [DEN_W-1:0]        p_den;

    spp_proj u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (x_valid),
        .i_xc     (x_xc),
        .i_yc     (x_yc),
        .i_zc     (x_zc),
        .i_fx     (r_fx),
        .i_fy     (r_fy),
        .o_valid  (p_valid),
        .o_nu     (p_nu),
        .o_nv     (p_nv),
        .o_den    (p_den),
        .o_behind (p_behind)
    );

    logic             du_valid, dv_valid;
    logic [PIX_W-1:0] du_q, dv_q;
    t_div_flags       du_f, dv_f;

    spp_div u_div_u (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (p_valid),
        .i_num    (p_nu),
        .i_den    (p_den),
        .i_behind (p_behind),
        .o_valid  (du_valid),
        .o_q      (du_q),
        .o_flags  (du_f)
    );

    spp_div u_div_v (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (p_valid),
        .i_num    (p_nv),
        .i_den    (p_den),
        .i_behind (p_behind),
        .o_valid  (dv_valid),
        .o_q      (dv_q),
        .o_flags  (dv_f)
    );

    logic signed [PIX_W-1:0] n_u, n_v;
    logic                    n_clip;

    always_comb begin
        if (du_f.sat_hi)      n_u = PIX_MAX;
        else if (du_f.sat_lo) n_u = PIX_MIN;
        else                  n_u = du_q;
        if (dv_f.sat_hi)      n_v = PIX_MAX;
        else if (dv_f.sat_lo) n_v = PIX_MIN;
        else                  n_v = dv_q;
        n_clip = du_f.sat_hi || du_f.sat_lo || dv_f.sat_hi || dv_f.sat_lo;
        if (du_f.behind) begin
            n_u    = '0;
            n_v    = '0;
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= du_valid && dv_valid;
        o_pixel_u       <= n_u;
        o_pixel_v       <= n_v;
        o_behind_camera <= du_f.behind;
        o_clipped       <= n_clip;
    end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the small-angle pinhole projection unit.
`timescale 1ns / 1ps
module tb_top;
    import spp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [PIX_W-1:0] u;
        logic signed [PIX_W-1:0] v;
        logic                    behind;
        logic                    clip;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [WORLD_W-1:0] i_world_x = '0;
    logic signed [WORLD_W-1:0] i_world_y = '0;
    logic signed [WORLD_W-1:0] i_world_z = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_valid;
    logic signed [PIX_W-1:0] o_pixel_u;
    logic signed [PIX_W-1:0] o_pixel_v;
    logic o_behind_camera;
    logic o_clipped;

    // pose copy
    logic signed [ROT_W-1:0]   pose_rot [3];
    logic signed [WORLD_W-1:0] pose_trans [3];
    logic [FOCAL_W-1:0]        focal [2];

    t_pixel pending_pixels [$];
    int mismatches = 0;
    int send_gap_pct = 0;

    always #1 i_clk = ~i_clk;

    small_angle_pinhole_projection_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_world_x(i_world_x), .i_world_y(i_world_y), .i_world_z(i_world_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_pixel_u(o_pixel_u), .o_pixel_v(o_pixel_v),
        .o_behind_camera(o_behind_camera), .o_clipped(o_clipped)
    );

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    function automatic longint round_q16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    // round(num / zc) to nearest, ties toward +inf
    function automatic longint pixel_quot(longint f, longint c, longint coord, longint zc);
        longint n, d, q;
        n = 2 * (f * coord + c * zc) + zc;
        d = 2 * zc;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic signed [PIX_W-1:0] saturate_pix(longint q, output logic clip);
        clip = 1'b0;
        if (q > 131071) begin
            clip = 1'b1;
            return 18'sh1FFFF;
        end
        if (q < -131072) begin
            clip = 1'b1;
            return 18'sh20000;
        end
        return q[PIX_W-1:0];
    endfunction

    function automatic t_pixel project_point(longint xw, longint yw, longint zw);
        t_pixel p;
        longint rx, ry, rz, xc, yc, zc;
        logic clip_u, clip_v;
        rx = pose_rot[0];
        ry = pose_rot[1];
        rz = pose_rot[2];
        xc = round_q16((xw <<< 16) - rz * yw + ry * zw + (longint'(pose_trans[0]) <<< 16));
        yc = round_q16(rz * xw + (yw <<< 16) - rx * zw + (longint'(pose_trans[1]) <<< 16));
        zc = round_q16(-ry * xw + rx * yw + (zw <<< 16) + (longint'(pose_trans[2]) <<< 16));
        p.u = '0;
        p.v = '0;
        p.clip = 1'b0;
        p.behind = (zc <= 0);
        if (!p.behind) begin
            p.u = saturate_pix(pixel_quot(focal[0], CX_Q4, xc, zc), clip_u);
            p.v = saturate_pix(pixel_quot(focal[1], CY_Q4, yc, zc), clip_v);
            p.clip = clip_u | clip_v;
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (o_valid) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result u=%0d v=%0d", o_pixel_u, o_pixel_v);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_u !== want.u || o_pixel_v !== want.v
                        || o_behind_camera !== want.behind || o_clipped !== want.clip) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp u=%0d v=%0d b=%0b c=%0b, got u=%0d v=%0d b=%0b c=%0b",
                                 want.u, want.v, want.behind, want.clip,
                                 o_pixel_u, o_pixel_v, o_behind_camera, o_clipped);
                end
            end
        end
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_pixel want;
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_world_x = x;
        i_world_y = y;
        i_world_z = z;
        do @(posedge i_clk); while (busy);
        want = project_point(longint'($signed(x)), longint'($signed(y)),
                             longint'($signed(z)));
        pending_pixels = {pending_pixels, want};
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ROT_X:   pose_rot[0] = data[ROT_W-1:0];
            REG_ROT_Y:   pose_rot[1] = data[ROT_W-1:0];
            REG_ROT_Z:   pose_rot[2] = data[ROT_W-1:0];
            REG_TRANS_X: pose_trans[0] = data;
            REG_TRANS_Y: pose_trans[1] = data;
            REG_TRANS_Z: pose_trans[2] = data;
            REG_FOCAL_X: focal[0] = data[FOCAL_W-1:0];
            REG_FOCAL_Y: focal[1] = data[FOCAL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // upper garbage bits must be ignored by the block
    task automatic set_pose(logic [17:0] rx, logic [17:0] ry, logic [17:0] rz,
                            logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                            logic [15:0] fx, logic [15:0] fy);
        drain();
        write_reg(REG_ROT_X, {14'($urandom_range(16383)), rx});
        write_reg(REG_ROT_Y, {14'($urandom_range(16383)), ry});
        write_reg(REG_ROT_Z, {14'($urandom_range(16383)), rz});
        write_reg(REG_TRANS_X, tx);
        write_reg(REG_TRANS_Y, ty);
        write_reg(REG_TRANS_Z, tz);
        write_reg(REG_FOCAL_X, {16'($urandom_range(65535)), fx});
        write_reg(REG_FOCAL_Y, {16'($urandom_range(65535)), fy});
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
    endtask

    task automatic send_near_point();
        send_point($urandom_range(20 << 16) - (10 << 16), $urandom_range(20 << 16) - (10 << 16),
                   $urandom_range(30 << 16, 1 << 12));
    endtask

    task automatic send_mixed_point();
        case ($urandom_range(9))
            0, 1:    send_point($urandom, $urandom, $urandom);
            2:       send_point($urandom_range(255) - 128, $urandom_range(255) - 128,
                                $urandom_range(4) - 2);
            default: send_near_point();
        endcase
    endtask

    task automatic test_defaults();
        // reset pose: identity rotation, no translation, focal 525
        send_point(0, 0, 1 << 16);
        send_point(0, 0, 0);
        send_point(0, 0, 32'hFFFF_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_point(1 << 16, 1 << 16, 1);
        send_point(1, 1, 2);
        send_point(1, 32'hFFFF_FFFF, 3);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    endtask

    task automatic test_pose_extremes();
        set_pose(18'h1FFFF, 18'h20000, 18'h1FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 16'hFFFF, 16'hFFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_point(0, 0, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        set_pose(18'h20000, 18'h1FFFF, 18'h20000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 16'h0000, 16'h0000);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(0, 0, 32'h7FFF_FFFF);
        set_pose('0, '0, '0, '0, '0, '0, 16'd8400, 16'd8400);
    endtask

    task automatic test_random_poses(int items, int gap_pct);
        send_gap_pct = gap_pct;
        for (int i = 0; i < items; i++) begin
            if (i % 100 == 0) begin
                if ($urandom_range(3) == 0)
                    set_pose(18'($urandom), 18'($urandom), 18'($urandom),
                             $urandom, $urandom, $urandom,
                             16'($urandom), 16'($urandom));
                else
                    set_pose(18'($urandom_range(6000) - 3000), 18'($urandom_range(6000) - 3000),
                             18'($urandom_range(6000) - 3000),
                             $urandom_range(4 << 16) - (2 << 16),
                             $urandom_range(4 << 16) - (2 << 16),
                             $urandom_range(4 << 16) - (2 << 16),
                             16'($urandom_range(16000, 4000)),
                             16'($urandom_range(16000, 4000)));
            end
            send_mixed_point();
        end
    endtask

    initial begin
        pose_rot = '{default: '0};
        pose_trans = '{default: '0};
        focal = '{FOCAL_RESET, FOCAL_RESET};
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_defaults();
        test_pose_extremes();
        test_random_poses(500, 32);
        test_random_poses(500, 87);
        test_random_poses(520, 0);
        drain();
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
